### rtl/core/srcoc_pkg.sv
// Package: shared types, codes and sizes for the shift register chain output controller.
package srcoc_pkg;

  localparam int MAX_CHAIN = 16;
  localparam int IDX_W     = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int CHAIN_W   = $clog2(MAX_CHAIN + 1);
  localparam int BITN_W    = CHAIN_W + 3;
  localparam int CMP_W     = (BITN_W > 8) ? BITN_W + 1 : 9;
  localparam int CFG_LEN_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [2:0] OP_WRITE_BYTE = 3'd0;
  localparam logic [2:0] OP_WRITE_BIT  = 3'd1;
  localparam logic [2:0] OP_BLOCK_ELEM = 3'd2;
  localparam logic [2:0] OP_SHIFT      = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BYTE_INVAL  = 2'd1;
  localparam logic [1:0] ST_BIT_INVAL   = 2'd2;
  localparam logic [1:0] ST_BLOCK_OVFL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLED = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic [7:0] bit_index;
    logic       bit_value;
    logic [7:0] block_length;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       frame_valid;
    logic [7:0] frame_byte;
    logic       latch_pulse;
    logic       clear_pulse;
    logic       output_enable_n;
    logic       last;
  } out_t;

endpackage

### rtl/core/shift_register_chain_output_controller_core.sv
// Top level: shadow bank, operation sequencer and result register for the shift register chain.
// A write, bit, block or clear result is registered from S_EXEC once the output register is free.
// A shift passes S_EXEC, then S_SHIFT registers its first beat once the output register is free.
// A new op is taken only in S_IDLE, after the last result or shift beat is loaded; a shift
// steps the single bank read port one byte per cycle down the chain while the output is free.
// Reset (rst, synchronous) zeroes the bank, chain length 1, outputs disabled.
module shift_register_chain_output_controller_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  srcoc_pkg::in_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output srcoc_pkg::out_t                 out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srcoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srcoc_pkg::CFG_LEN_W-1:0] cfg_data
);
  import srcoc_pkg::*;

  state_t                 state, state_next;
  in_t                    item;
  logic [7:0]             bank [MAX_CHAIN];
  logic [CFG_LEN_W-1:0]   chain_length;
  logic                   output_enabled;
  logic [IDX_W-1:0]       shift_idx;

  logic [CHAIN_W-1:0]     chain_eff;
  logic                   out_free;
  logic                   load_out;
  out_t                   result;
  logic [IDX_W-1:0]       rd_idx;
  logic [7:0]             rd_data;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [7:0]             wr_data;
  logic                   clr_bank;
  logic [7:0]             bit_mask;
  logic                   byte_ok, bit_ok, block_fits, elem_ok;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    if (chain_length == '0) begin
      chain_eff = CHAIN_W'(1);
    end else if (32'(chain_length) > MAX_CHAIN) begin
      chain_eff = CHAIN_W'(MAX_CHAIN);
    end else begin
      chain_eff = CHAIN_W'(chain_length);
    end
  end

  assign byte_ok    = CMP_W'(item.byte_index) < CMP_W'(chain_eff);
  assign bit_ok     = CMP_W'(item.bit_index) < CMP_W'({chain_eff, 3'b000});
  assign block_fits = CMP_W'(item.block_length) <= CMP_W'(chain_eff);
  assign elem_ok    = item.byte_index < item.block_length;
  assign bit_mask   = 8'(1) << item.bit_index[2:0];
  assign rd_data    = bank[rd_idx];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (item.opcode == OP_SHIFT) begin
          state_next = S_SHIFT;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (out_free && shift_idx == '0) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    load_out = 1'b0;
    wr_en    = 1'b0;
    clr_bank = 1'b0;
    wr_idx   = item.byte_index[IDX_W-1:0];
    wr_data  = item.byte_value;
    rd_idx   = item.bit_index[IDX_W+2:3];
    result   = '{status: ST_OK, frame_valid: 1'b0, frame_byte: 8'h00, latch_pulse: 1'b0,
                 clear_pulse: 1'b0, output_enable_n: !output_enabled, last: 1'b1};
    case (state)
      S_EXEC: begin
        load_out = out_free && (item.opcode != OP_SHIFT);
        case (item.opcode)
          OP_WRITE_BYTE: begin
            if (byte_ok) wr_en = load_out;
            else result.status = ST_BYTE_INVAL;
          end
          OP_WRITE_BIT: begin
            wr_idx  = rd_idx;
            wr_data = item.bit_value ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
            if (bit_ok) wr_en = load_out;
            else result.status = ST_BIT_INVAL;
          end
          OP_BLOCK_ELEM: begin
            if (!block_fits) result.status = ST_BLOCK_OVFL;
            else if (!elem_ok) result.status = ST_BYTE_INVAL;
            else wr_en = load_out;
          end
          OP_CLEAR: begin
            clr_bank           = load_out;
            result.latch_pulse = 1'b1;
            result.clear_pulse = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        load_out           = out_free;
        rd_idx             = shift_idx;
        result.frame_valid = 1'b1;
        result.frame_byte  = rd_data;
        result.latch_pulse = (shift_idx == '0);
        result.last        = (shift_idx == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      chain_length   <= CFG_LEN_W'(1);
      output_enabled <= 1'b0;
      out_valid      <= 1'b0;
      shift_idx      <= '0;
      for (int i = 0; i < MAX_CHAIN; i++) bank[i] <= 8'h00;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHAIN_LENGTH:   chain_length   <= cfg_data;
          CFG_OUTPUT_ENABLED: output_enabled <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == S_EXEC) begin
        shift_idx <= IDX_W'(chain_eff - CHAIN_W'(1));
      end else if (state == S_SHIFT && out_free && shift_idx != '0) begin
        shift_idx <= shift_idx - IDX_W'(1);
      end
      if (clr_bank) begin
        for (int i = 0; i < MAX_CHAIN; i++) bank[i] <= 8'h00;
      end else if (wr_en) begin
        bank[wr_idx] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_data;
    if (load_out) out_data <= result;
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("accepted item did not enter execution");

  a_latch_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.latch_pulse |-> out_data.last)
    else $error("latch pulse on a beat that is not last");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> CHAIN_W'(shift_idx) < chain_eff)
    else $error("shift index beyond chain");

  a_shift_frame: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT && out_free |=> out_valid && out_data.frame_valid)
    else $error("shift beat missing frame");

endmodule

### test/srcoc_chain_checker.sv
// Checker: predicts the result beats of the shift register chain controller and compares them.
module srcoc_chain_checker
  import srcoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_t                 out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_LEN_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   pending
);

  logic [7:0]           shadow [MAX_CHAIN];
  logic [CFG_LEN_W-1:0] chain_reg;
  logic                 enable_reg;
  out_t                 frames_due [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic int chain_in_use();
    int n;
    n = chain_reg;
    if (n == 0) n = 1;
    if (n > MAX_CHAIN) n = MAX_CHAIN;
    return n;
  endfunction

  task automatic predict_op(input in_t op);
    int   n;
    out_t r;
    n = chain_in_use();
    r = '0;
    r.output_enable_n = !enable_reg;
    r.last = 1'b1;
    case (op.opcode)
      OP_WRITE_BYTE: begin
        if (op.byte_index < n) shadow[op.byte_index[3:0]] = op.byte_value;
        else r.status = ST_BYTE_INVAL;
      end
      OP_WRITE_BIT: begin
        if (op.bit_index > n * 8 - 1) r.status = ST_BIT_INVAL;
        else shadow[op.bit_index[6:3]][op.bit_index[2:0]] = op.bit_value;
      end
      OP_BLOCK_ELEM: begin
        if (op.block_length > n) r.status = ST_BLOCK_OVFL;
        else if (op.byte_index >= op.block_length) r.status = ST_BYTE_INVAL;
        else shadow[op.byte_index[3:0]] = op.byte_value;
      end
      OP_SHIFT: begin
        for (int k = n - 1; k >= 0; k--) begin
          r.frame_valid = 1'b1;
          r.frame_byte  = shadow[k];
          r.latch_pulse = (k == 0);
          r.last        = (k == 0);
          frames_due.push_back(r);
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < MAX_CHAIN; k++) shadow[k] = 8'h00;
        r.latch_pulse = 1'b1;
        r.clear_pulse = 1'b1;
      end
      default: ;
    endcase
    if (op.opcode != OP_SHIFT) frames_due.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int k = 0; k < MAX_CHAIN; k++) shadow[k] = 8'h00;
      chain_reg  = CFG_LEN_W'(1);
      enable_reg = 1'b0;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CHAIN_LENGTH) chain_reg = cfg_data;
        else enable_reg = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          $display("%0t: beat expected none actual %p", $time, out_data);
        end else begin
          want = frames_due.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("frame_valid", want.frame_valid, out_data.frame_valid);
          check_field("frame_byte", want.frame_byte, out_data.frame_byte);
          check_field("latch_pulse", want.latch_pulse, out_data.latch_pulse);
          check_field("clear_pulse", want.clear_pulse, out_data.clear_pulse);
          check_field("output_enable_n", want.output_enable_n, out_data.output_enable_n);
          check_field("last", want.last, out_data.last);
        end
      end
      if (in_valid && in_ready) predict_op(in_data);
    end
    pending = frames_due.size();
  end

endmodule

### test/shift_register_chain_output_controller_core_test.sv
// Testbench top: clock, reset, operation and register stimulus, and the final verdict.
module shift_register_chain_output_controller_core_test;
  import srcoc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_LEN_W-1:0] cfg_data = '0;
  int                   mismatches;
  int                   pending;

  bit calm = 1'b0;
  bit choke_req = 1'b0;
  bit choke_done = 1'b0;
  int gap_odds = 4;
  int chain_n = 1;
  int sent = 0;

  shift_register_chain_output_controller_core dut (.*);
  srcoc_chain_checker chk (.*);

  always #5 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold;
    forever begin
      if (choke_req && !choke_done) begin
        choke_done = 1'b1;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 6);
        repeat (hold) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(1, 12);
        repeat (hold) @(posedge clk);
      end
    end
  end

  task automatic push_op(input in_t op);
    int gap;
    if (!calm && gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_LEN_W-1:0] len, input logic en);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CHAIN_LENGTH;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_OUTPUT_ENABLED;
    cfg_data  <= CFG_LEN_W'(en);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chain_n = (len == 0) ? 1 : (len > MAX_CHAIN) ? MAX_CHAIN : len;
  endtask

  function automatic in_t random_op(input int n);
    in_t op;
    int  pick;
    op = in_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      op.opcode = OP_WRITE_BYTE;
      if ($urandom_range(0, 4) != 0) op.byte_index = 8'($urandom_range(0, n - 1));
    end else if (pick < 47) begin
      op.opcode = OP_WRITE_BIT;
      if ($urandom_range(0, 4) != 0) op.bit_index = 8'($urandom_range(0, 8 * n - 1));
    end else if (pick < 67) begin
      op.opcode = OP_BLOCK_ELEM;
      if ($urandom_range(0, 4) != 0) begin
        op.block_length = 8'($urandom_range(1, n));
        op.byte_index = 8'($urandom_range(0, op.block_length - 1));
      end
    end else if (pick < 85) begin
      op.opcode = OP_SHIFT;
    end else if (pick < 93) begin
      op.opcode = OP_CLEAR;
    end else begin
      op.opcode = OP_CLEAR + 3'($urandom_range(1, 3));
    end
    return op;
  endfunction

  // write a whole block in order, then shift it out
  task automatic send_block(input int n);
    int  blen;
    in_t op;
    blen = $urandom_range(1, n);
    for (int i = 0; i < blen; i++) begin
      op = in_t'({$urandom, $urandom});
      op.opcode = OP_BLOCK_ELEM;
      op.byte_index = 8'(i);
      op.block_length = 8'(blen);
      push_op(op);
    end
    op = in_t'({$urandom, $urandom});
    op.opcode = OP_SHIFT;
    push_op(op);
  endtask

  initial begin
    logic [CFG_LEN_W-1:0] lens [6];
    int                   goal;
    lens = '{5'd0, 5'd31, 5'd7, 5'd16, 5'd17, 5'd1};
    lens[5] = CFG_LEN_W'($urandom_range(1, 16));
    wait (!rst);
    @(posedge clk);

    set_config(5'd16, 1'b1);
    push_op(in_t'{OP_WRITE_BYTE, 8'hFF, 8'd0, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_WRITE_BYTE, 8'hA5, 8'd15, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_WRITE_BYTE, 8'h11, 8'd16, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_WRITE_BYTE, 8'h00, 8'd255, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_WRITE_BIT, 8'h00, 8'd0, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_WRITE_BIT, 8'h00, 8'd0, 8'd127, 1'b1, 8'd0});
    push_op(in_t'{OP_WRITE_BIT, 8'h00, 8'd0, 8'd128, 1'b1, 8'd0});
    push_op(in_t'{OP_WRITE_BIT, 8'h00, 8'd0, 8'd255, 1'b1, 8'd0});
    push_op(in_t'{OP_WRITE_BIT, 8'h00, 8'd0, 8'd100, 1'b1, 8'd0});
    push_op(in_t'{OP_BLOCK_ELEM, 8'h5A, 8'd15, 8'd0, 1'b0, 8'd16});
    push_op(in_t'{OP_BLOCK_ELEM, 8'h77, 8'd0, 8'd0, 1'b0, 8'd17});
    push_op(in_t'{OP_BLOCK_ELEM, 8'h77, 8'd0, 8'd0, 1'b0, 8'd255});
    push_op(in_t'{OP_BLOCK_ELEM, 8'h77, 8'd4, 8'd0, 1'b0, 8'd4});
    push_op(in_t'{OP_BLOCK_ELEM, 8'h77, 8'd0, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_BLOCK_ELEM, 8'h3C, 8'd0, 8'd0, 1'b0, 8'd1});
    push_op(in_t'{OP_SHIFT, 8'h00, 8'd0, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF});
    push_op(in_t'{OP_SHIFT, 8'h00, 8'd0, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_CLEAR + 3'd1, 8'hFF, 8'd0, 8'd0, 1'b1, 8'd0});
    push_op(in_t'{OP_CLEAR + 3'd2, 8'h00, 8'd0, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_CLEAR + 3'd3, 8'h00, 8'd0, 8'd0, 1'b0, 8'd0});
    drain();

    set_config(5'd0, 1'b0);
    push_op(in_t'{OP_WRITE_BYTE, 8'h81, 8'd0, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_WRITE_BYTE, 8'h81, 8'd1, 8'd0, 1'b0, 8'd0});
    push_op(in_t'{OP_WRITE_BIT, 8'h00, 8'd0, 8'd7, 1'b0, 8'd0});
    push_op(in_t'{OP_WRITE_BIT, 8'h00, 8'd0, 8'd8, 1'b1, 8'd0});
    push_op(in_t'{OP_SHIFT, 8'h00, 8'd0, 8'd0, 1'b0, 8'd0});
    drain();

    for (int p = 0; p < 6; p++) begin
      set_config(lens[p], 1'($urandom_range(0, 1)));
      gap_odds = (p == 3) ? 0 : $urandom_range(2, 6);
      if (p == 5) calm = 1'b1;
      if (p == 1) choke_req = 1'b1;
      goal = sent + 47;
      while (sent < goal) begin
        if ($urandom_range(0, 9) == 0) send_block(chain_n);
        else push_op(random_op(chain_n));
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### shift_register_chain_output_controller_core.f
rtl/core/srcoc_pkg.sv
rtl/core/shift_register_chain_output_controller_core.sv
test/srcoc_chain_checker.sv
test/shift_register_chain_output_controller_core_test.sv
